@@ hdl/wmst_pkg.sv @@
// Shared types and constants for the weekly mode schedule table.
// Used by wmst_dp, wmst_ctrl and weekly_mode_schedule_table_core; no dependencies.
`default_nettype none

package wmst_pkg;

    // Table geometry
    localparam int DAYS                = 7;
    localparam int ENTRIES_PER_DAY_DEF = 16;

    // Field widths
    localparam int DAY_W    = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MODE_W   = 4;
    localparam int KEY_W    = HOUR_W + MINUTE_W;
    localparam int CFG_IDX_W = 4;

    // Calendar limits
    localparam logic [DAY_W-1:0]    LAST_DAY   = DAY_W'(6);
    localparam logic [HOUR_W-1:0]   MAX_HOUR   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] MAX_MINUTE = MINUTE_W'(59);

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FROSTFREE_MODE = CFG_IDX_W'(1);

    // Configuration reset values
    localparam logic [MODE_W-1:0] UNKNOWN_MODE_RST  = MODE_W'(7);
    localparam logic [MODE_W-1:0] FROSTFREE_MODE_RST = MODE_W'(1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_AUTO = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_INVALID  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic                operation;
        logic [DAY_W-1:0]    weekday;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [MODE_W-1:0]   run_target;
        logic [MODE_W-1:0]   dhw_target;
        logic                auto_active;
    } in_t;

    typedef struct packed {
        status_t             status;
        logic [MODE_W-1:0]   run_mode;
        logic [MODE_W-1:0]   dhw_mode;
        logic                changed;
    } out_t;

    // One stored schedule entry
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [MODE_W-1:0]   run;
        logic [MODE_W-1:0]   dhw;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_CHK,
        S_ADD_CMP,
        S_ADD_DONE,
        S_TICK_CHK,
        S_TICK_CMP,
        S_TICK_END
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    add_init;
        logic    rd_add;
        logic    wr_shift;
        logic    wr_new;
        logic    tick_init;
        logic    rd_tick;
        logic    tick_take;
        logic    day_back;
        logic    post;
        status_t post_code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_add;
        logic add_bad;
        logic day_bad;
        logic day_full;
        logic auto_on;
        logic idx_zero;
        logic idx_end;
        logic entry_le;
        logic found;
        logic week_done;
        logic res_free;
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/weekly_mode_schedule_table_core.sv @@
// Top level of the weekly mode schedule table: joins wmst_ctrl and wmst_dp.
// Depends on wmst_pkg, wmst_ctrl and wmst_dp.
`default_nettype none

// Weekly mode schedule table. Each input transfer is either an add, which inserts a
// timed entry into one weekday's sorted list, or a tick, which returns the run and
// hot-water modes in force at the given day and time; every input transfer yields
// exactly one result transfer. Items are handled one at a time through a single-port
// entry memory with registered read.
// - Add: reads the day's entries from the top down, comparing each with the new time
//   and moving each later entry up a slot, then writes the new entry into the free slot.
// - Tick: reads today's entries in order, taking each not later than the given time,
//   and stops at a later entry or the day's end; with nothing found it steps back one
//   whole day at a time, up to a full week. Each entry takes a memory read followed
//   by a compare.
// - Errors and the not-automatic case are answered without touching the memory.
// The input is ready again in the cycle after the result is posted. A new input
// transfer is taken while the previous result still waits at the output; a result not
// yet taken holds the next result back until it is transferred. There is no clearing
// pass after reset.
module weekly_mode_schedule_table_core #(
    parameter int ENTRIES_PER_DAY = wmst_pkg::ENTRIES_PER_DAY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire wmst_pkg::in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output wmst_pkg::out_t                         out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wmst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wmst_pkg::MODE_W-1:0]       cfg_data
);

    wmst_pkg::cmd_t cmd;
    wmst_pkg::sts_t sts;

    // Configuration writes land at once
    assign cfg_ready = 1'b1;

    wmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wmst_dp #(
        .EPD (ENTRIES_PER_DAY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // A result is posted only into a free output register
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!out_valid || out_ready))
        else $error("result posted over a pending result");

    // A result is posted only while an item is in progress
    a_post_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> !in_ready)
        else $error("result posted with no item in progress");

    // Output valid rises only after a post
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.post))
        else $error("output valid without a posted result");

    // Memory never written and read in the same cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_shift || cmd.wr_new) |-> !(cmd.rd_add || cmd.rd_tick))
        else $error("memory read and write in one cycle");

endmodule

`default_nettype wire

@@ hdl/wmst_dp.sv @@
// Datapath of the weekly mode schedule table: entry memory, day counts, walk registers,
// configuration and the result register. Driven by wmst_ctrl; depends on wmst_pkg.
`default_nettype none

module wmst_dp #(
    parameter int EPD = wmst_pkg::ENTRIES_PER_DAY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire wmst_pkg::in_t                     in_data,
    input  wire logic                              cfg_valid,
    input  wire logic [wmst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wmst_pkg::MODE_W-1:0]       cfg_data,
    input  wire wmst_pkg::cmd_t                    cmd,
    output wmst_pkg::sts_t                         sts,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output wmst_pkg::out_t                         out_data
);

    localparam int CW    = $clog2(EPD + 1);
    localparam int DEPTH = wmst_pkg::DAYS * EPD;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] EPD_A = AW'(EPD);
    localparam logic [CW-1:0] EPD_C = CW'(EPD);
    localparam logic [wmst_pkg::DAY_W-1:0] FIRST_WALK_DAY = '0;
    localparam logic [wmst_pkg::DAY_W-1:0] LAST_WALK = wmst_pkg::DAY_W'(wmst_pkg::DAYS - 1);

    wmst_pkg::in_t                       item_reg;
    logic [wmst_pkg::DAY_W-1:0]          day_reg;
    logic [wmst_pkg::DAY_W-1:0]          day_next;
    logic [wmst_pkg::KEY_W-1:0]          now_reg;
    logic [wmst_pkg::KEY_W-1:0]          now_next;
    logic [CW-1:0]                       idx_reg;
    logic [CW-1:0]                       idx_next;
    logic [wmst_pkg::DAY_W-1:0]          walked_reg;
    logic [wmst_pkg::DAY_W-1:0]          walked_next;
    logic                                found_reg;
    logic                                found_next;
    logic [wmst_pkg::MODE_W-1:0]         run_reg;
    logic [wmst_pkg::MODE_W-1:0]         run_next;
    logic [wmst_pkg::MODE_W-1:0]         dhw_reg;
    logic [wmst_pkg::MODE_W-1:0]         dhw_next;
    logic [wmst_pkg::MODE_W-1:0]         last_run_reg;
    logic [wmst_pkg::MODE_W-1:0]         last_run_next;
    logic [wmst_pkg::MODE_W-1:0]         last_dhw_reg;
    logic [wmst_pkg::MODE_W-1:0]         last_dhw_next;
    logic [wmst_pkg::MODE_W-1:0]         unknown_reg;
    logic [wmst_pkg::MODE_W-1:0]         frost_reg;
    logic [CW-1:0]                       day_count_reg [wmst_pkg::DAYS];
    wmst_pkg::out_t                      res_reg;
    wmst_pkg::out_t                      res_next;
    logic                                res_valid_reg;
    logic                                res_valid_next;

    wmst_pkg::entry_t                    mem [DEPTH];
    wmst_pkg::entry_t                    rd_reg;
    wmst_pkg::entry_t                    wr_data;
    logic [AW-1:0]                       rd_addr;
    logic [AW-1:0]                       wr_addr;
    logic [CW-1:0]                       rd_idx;
    logic [AW-1:0]                       day_base;
    logic [CW-1:0]                       cnt_cur;
    logic                                mem_we;
    logic                                mem_re;

    // Count of the day under work; an invalid day reads as empty
    always_comb
    begin
        if (day_reg > wmst_pkg::LAST_DAY)
        begin
            cnt_cur = '0;
        end
        else
        begin
            cnt_cur = day_count_reg[day_reg];
        end
    end

    // Memory addressing: row base of the day plus the slot index
    always_comb
    begin
        day_base = AW'(day_reg) * EPD_A;
        rd_idx   = cmd.rd_add ? (idx_reg - 1'b1) : idx_reg;
        rd_addr  = AW'(day_base + AW'(rd_idx));
        wr_addr  = AW'(day_base + AW'(idx_reg));
        mem_we   = cmd.wr_shift | cmd.wr_new;
        mem_re   = cmd.rd_add | cmd.rd_tick;
        if (cmd.wr_shift)
        begin
            wr_data = rd_reg;
        end
        else
        begin
            wr_data.hour   = item_reg.hour;
            wr_data.minute = item_reg.minute;
            wr_data.run    = item_reg.run_target;
            wr_data.dhw    = item_reg.dhw_target;
        end
    end

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.op_add    = (item_reg.operation == wmst_pkg::OP_ADD);
        sts.add_bad   = (item_reg.weekday > wmst_pkg::LAST_DAY)
                     || (item_reg.hour > wmst_pkg::MAX_HOUR)
                     || (item_reg.minute > wmst_pkg::MAX_MINUTE)
                     || (item_reg.run_target > unknown_reg)
                     || (item_reg.dhw_target > unknown_reg);
        sts.day_bad   = (item_reg.weekday > wmst_pkg::LAST_DAY);
        sts.day_full  = (cnt_cur >= EPD_C);
        sts.auto_on   = item_reg.auto_active;
        sts.idx_zero  = (idx_reg == '0);
        sts.idx_end   = (idx_reg >= cnt_cur);
        sts.entry_le  = ({rd_reg.hour, rd_reg.minute} <= now_reg);
        sts.found     = found_reg;
        sts.week_done = (walked_reg == LAST_WALK);
        sts.res_free  = !res_valid_reg || out_ready;
    end

    // Walk and result next-state logic
    always_comb
    begin
        day_next       = day_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        walked_next    = walked_reg;
        found_next     = found_reg;
        run_next       = run_reg;
        dhw_next       = dhw_reg;
        last_run_next  = last_run_reg;
        last_dhw_next  = last_dhw_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end

        // Latch day and time key of a new item
        if (cmd.load)
        begin
            day_next = in_data.weekday;
            now_next = {in_data.hour, in_data.minute};
        end

        // Start an insertion from the top of the day
        if (cmd.add_init)
        begin
            idx_next = cnt_cur;
        end

        // Move one entry up a slot
        if (cmd.wr_shift)
        begin
            idx_next = idx_reg - 1'b1;
        end

        // Start a walk over today
        if (cmd.tick_init)
        begin
            idx_next    = '0;
            walked_next = FIRST_WALK_DAY;
            found_next  = 1'b0;
            run_next    = unknown_reg;
            dhw_next    = unknown_reg;
        end

        // Take a past entry, keeping modes that are not the unknown code
        if (cmd.tick_take)
        begin
            if (rd_reg.run != unknown_reg)
            begin
                run_next = rd_reg.run;
            end
            if (rd_reg.dhw != unknown_reg)
            begin
                dhw_next = rd_reg.dhw;
            end
            found_next = 1'b1;
            idx_next   = idx_reg + 1'b1;
        end

        // Step back one day, whole day counts
        if (cmd.day_back)
        begin
            day_next    = (day_reg == '0) ? LAST_WALK : (day_reg - 1'b1);
            now_next    = {wmst_pkg::MAX_HOUR, wmst_pkg::MAX_MINUTE};
            idx_next    = '0;
            walked_next = walked_reg + 1'b1;
        end

        // Post the result and apply modes
        if (cmd.post)
        begin
            res_valid_next    = 1'b1;
            res_next.status   = cmd.post_code;
            res_next.run_mode = '0;
            res_next.dhw_mode = '0;
            res_next.changed  = 1'b0;
            if (cmd.post_code == wmst_pkg::ST_NOT_AUTO)
            begin
                res_next.run_mode = frost_reg;
                res_next.dhw_mode = frost_reg;
                last_run_next     = frost_reg;
                last_dhw_next     = frost_reg;
            end
            else if ((cmd.post_code == wmst_pkg::ST_OK)
                  && (item_reg.operation == wmst_pkg::OP_TICK))
            begin
                res_next.run_mode = run_reg;
                res_next.dhw_mode = dhw_reg;
                res_next.changed  = (run_reg != last_run_reg) || (dhw_reg != last_dhw_reg);
                last_run_next     = run_reg;
                last_dhw_next     = dhw_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        day_reg <= day_next;
        now_reg <= now_next;
        idx_reg <= idx_next;
        run_reg <= run_next;
        dhw_reg <= dhw_next;
        res_reg <= res_next;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walked_reg    <= '0;
            found_reg     <= 1'b0;
            last_run_reg  <= wmst_pkg::UNKNOWN_MODE_RST;
            last_dhw_reg  <= wmst_pkg::UNKNOWN_MODE_RST;
            unknown_reg   <= wmst_pkg::UNKNOWN_MODE_RST;
            frost_reg     <= wmst_pkg::FROSTFREE_MODE_RST;
            res_valid_reg <= 1'b0;
            for (int d = 0; d < wmst_pkg::DAYS; d++)
            begin
                day_count_reg[d] <= '0;
            end
        end
        else
        begin
            walked_reg    <= walked_next;
            found_reg     <= found_next;
            last_run_reg  <= last_run_next;
            last_dhw_reg  <= last_dhw_next;
            res_valid_reg <= res_valid_next;
            if (cmd.wr_new)
            begin
                day_count_reg[day_reg] <= cnt_cur + 1'b1;
            end
            if (cfg_valid && (cfg_index == wmst_pkg::CFG_UNKNOWN_MODE))
            begin
                unknown_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == wmst_pkg::CFG_FROSTFREE_MODE))
            begin
                frost_reg <= cfg_data;
            end
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

@@ hdl/wmst_ctrl.sv @@
// Sequencer of the weekly mode schedule table: steps insertion and the backward walk.
// Issues commands to wmst_dp and reads its status; depends on wmst_pkg.
`default_nettype none

module wmst_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wmst_pkg::sts_t    sts,
    output wmst_pkg::cmd_t         cmd
);

    wmst_pkg::state_t state_reg;
    wmst_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmst_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wmst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wmst_pkg::S_DISPATCH;
                end
            end
            wmst_pkg::S_DISPATCH:
            begin
                if (sts.op_add)
                begin
                    if (sts.add_bad || sts.day_full)
                    begin
                        if (sts.res_free)
                        begin
                            state_next = wmst_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = wmst_pkg::S_ADD_CHK;
                    end
                end
                else if (sts.day_bad || !sts.auto_on)
                begin
                    if (sts.res_free)
                    begin
                        state_next = wmst_pkg::S_IDLE;
                    end
                end
                else
                begin
                    state_next = wmst_pkg::S_TICK_CHK;
                end
            end
            wmst_pkg::S_ADD_CHK:
            begin
                state_next = sts.idx_zero ? wmst_pkg::S_ADD_DONE : wmst_pkg::S_ADD_CMP;
            end
            wmst_pkg::S_ADD_CMP:
            begin
                state_next = sts.entry_le ? wmst_pkg::S_ADD_DONE : wmst_pkg::S_ADD_CHK;
            end
            wmst_pkg::S_ADD_DONE:
            begin
                if (sts.res_free)
                begin
                    state_next = wmst_pkg::S_IDLE;
                end
            end
            wmst_pkg::S_TICK_CHK:
            begin
                state_next = sts.idx_end ? wmst_pkg::S_TICK_END : wmst_pkg::S_TICK_CMP;
            end
            wmst_pkg::S_TICK_CMP:
            begin
                state_next = sts.entry_le ? wmst_pkg::S_TICK_CHK : wmst_pkg::S_TICK_END;
            end
            wmst_pkg::S_TICK_END:
            begin
                if (sts.found || sts.week_done)
                begin
                    if (sts.res_free)
                    begin
                        state_next = wmst_pkg::S_IDLE;
                    end
                end
                else
                begin
                    state_next = wmst_pkg::S_TICK_CHK;
                end
            end
            default:
            begin
                state_next = wmst_pkg::S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.post_code = wmst_pkg::ST_OK;
        case (state_reg)
            wmst_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            wmst_pkg::S_DISPATCH:
            begin
                if (sts.op_add)
                begin
                    if (sts.add_bad)
                    begin
                        cmd.post      = sts.res_free;
                        cmd.post_code = wmst_pkg::ST_INVALID;
                    end
                    else if (sts.day_full)
                    begin
                        cmd.post      = sts.res_free;
                        cmd.post_code = wmst_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.add_init = 1'b1;
                    end
                end
                else if (sts.day_bad)
                begin
                    cmd.post      = sts.res_free;
                    cmd.post_code = wmst_pkg::ST_INVALID;
                end
                else if (!sts.auto_on)
                begin
                    cmd.post      = sts.res_free;
                    cmd.post_code = wmst_pkg::ST_NOT_AUTO;
                end
                else
                begin
                    cmd.tick_init = 1'b1;
                end
            end
            wmst_pkg::S_ADD_CHK:
            begin
                cmd.wr_new = sts.idx_zero;
                cmd.rd_add = !sts.idx_zero;
            end
            wmst_pkg::S_ADD_CMP:
            begin
                cmd.wr_new   = sts.entry_le;
                cmd.wr_shift = !sts.entry_le;
            end
            wmst_pkg::S_ADD_DONE:
            begin
                cmd.post = sts.res_free;
            end
            wmst_pkg::S_TICK_CHK:
            begin
                cmd.rd_tick = !sts.idx_end;
            end
            wmst_pkg::S_TICK_CMP:
            begin
                cmd.tick_take = sts.entry_le;
            end
            wmst_pkg::S_TICK_END:
            begin
                if (sts.found)
                begin
                    cmd.post = sts.res_free;
                end
                else if (sts.week_done)
                begin
                    cmd.post      = sts.res_free;
                    cmd.post_code = wmst_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.day_back = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/wmst_result_checker.sv @@
// Result checker for weekly_mode_schedule_table_core: follows the input, output and
// configuration transfers, predicts every result and compares it field by field.
// Depends on wmst_pkg.

module wmst_result_checker
    import wmst_pkg::*;
#(
    parameter int ENTRIES_PER_DAY = ENTRIES_PER_DAY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_t                  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_t                 out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MODE_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int REPORT_MAX = 10;

    // Shadow copy of the schedule and the applied modes
    entry_t            sched [DAYS][ENTRIES_PER_DAY];
    int                fill [DAYS];
    logic [MODE_W-1:0] last_run;
    logic [MODE_W-1:0] last_dhw;
    logic [MODE_W-1:0] unk_code;
    logic [MODE_W-1:0] frost_code;
    out_t              results_due [$];

    // Insert an entry after every entry of its day with an equal or earlier time
    function automatic out_t add_entry(input in_t it);
        out_t            r;
        logic [DAY_W-1:0] d;
        int              n;
        int              pos;
        int              i;
        r = '0;
        d = it.weekday;
        r.status = ST_OK;
        if (d > LAST_DAY || it.hour > MAX_HOUR || it.minute > MAX_MINUTE
            || it.run_target > unk_code || it.dhw_target > unk_code)
            r.status = ST_INVALID;
        else if (fill[d] >= ENTRIES_PER_DAY)
            r.status = ST_FULL;
        else
        begin
            n = fill[d];
            pos = 0;
            while (pos < n && {sched[d][pos].hour, sched[d][pos].minute} <= {it.hour, it.minute})
                pos++;
            for (i = n; i > pos; i--)
                sched[d][i] = sched[d][i-1];
            sched[d][pos].hour   = it.hour;
            sched[d][pos].minute = it.minute;
            sched[d][pos].run    = it.run_target;
            sched[d][pos].dhw    = it.dhw_target;
            fill[d] = n + 1;
        end
        return r;
    endfunction

    // Find the modes in force: today's past entries, else whole earlier days
    function automatic out_t eval_tick(input in_t it);
        out_t              r;
        logic [DAY_W-1:0]  d;
        logic [KEY_W-1:0]  now;
        logic [MODE_W-1:0] run;
        logic [MODE_W-1:0] dhw;
        bit                found;
        bit                past;
        int                walked;
        int                i;
        r = '0;
        d = it.weekday;
        now = {it.hour, it.minute};
        run = unk_code;
        dhw = unk_code;
        found = 1'b0;
        if (d > LAST_DAY)
            r.status = ST_INVALID;
        else if (!it.auto_active)
        begin
            last_run = frost_code;
            last_dhw = frost_code;
            r.status = ST_NOT_AUTO;
            r.run_mode = frost_code;
            r.dhw_mode = frost_code;
        end
        else
        begin
            for (walked = 0; walked < DAYS && !found; walked++)
            begin
                past = 1'b0;
                for (i = 0; i < fill[d] && !past; i++)
                begin
                    if ({sched[d][i].hour, sched[d][i].minute} > now)
                        past = 1'b1;
                    else
                    begin
                        if (sched[d][i].run != unk_code)
                            run = sched[d][i].run;
                        if (sched[d][i].dhw != unk_code)
                            dhw = sched[d][i].dhw;
                        found = 1'b1;
                    end
                end
                // Step back one day and look at all of it
                if (!found)
                begin
                    now = {MAX_HOUR, MAX_MINUTE};
                    d = (d == '0) ? LAST_DAY : d - 1'b1;
                end
            end
            if (!found)
                r.status = ST_EMPTY;
            else
            begin
                r.status = ST_OK;
                r.run_mode = run;
                r.dhw_mode = dhw;
                r.changed = (run != last_run) || (dhw != last_dhw);
                last_run = run;
                last_dhw = dhw;
            end
        end
        return r;
    endfunction

    // Track configuration, check results, then queue the prediction for new input
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int d = 0; d < DAYS; d++)
                fill[d] = 0;
            unk_code = UNKNOWN_MODE_RST;
            frost_code = FROSTFREE_MODE_RST;
            last_run = UNKNOWN_MODE_RST;
            last_dhw = UNKNOWN_MODE_RST;
            results_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_UNKNOWN_MODE)
                    unk_code = cfg_data;
                else if (cfg_index == CFG_FROSTFREE_MODE)
                    frost_code = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected result transfer: status %0d run %0d dhw %0d changed %0d",
                                 out_data.status, out_data.run_mode, out_data.dhw_mode,
                                 out_data.changed);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want.status != out_data.status || want.run_mode != out_data.run_mode
                        || want.dhw_mode != out_data.dhw_mode || want.changed != out_data.changed)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display("result mismatch (want/got): status %0d/%0d run %0d/%0d dhw %0d/%0d changed %0d/%0d",
                                     want.status, out_data.status, want.run_mode,
                                     out_data.run_mode, want.dhw_mode, out_data.dhw_mode,
                                     want.changed, out_data.changed);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.operation == OP_ADD)
                    results_due.push_back(add_entry(in_data));
                else
                    results_due.push_back(eval_tick(in_data));
            end
            outstanding <= results_due.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for weekly_mode_schedule_table_core: clock, reset, directed and random
// add/tick transfers, configuration phases, stalls and the verdict.
// Depends on wmst_pkg, weekly_mode_schedule_table_core and wmst_result_checker.

module tb_top;
    import wmst_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int IDLE_PCT    = 31;
    localparam int ADD_PCT     = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 50;
    localparam logic [DAY_W-1:0] FILL_DAY = DAY_W'(5);
    // Unmapped register index; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MODE_W-1:0]    cfg_data;
    int                   mismatches;
    int                   outstanding;
    int                   quiet = 0;
    bit                   steady = 1'b0;
    logic [MODE_W-1:0]    cur_unk = UNKNOWN_MODE_RST;

    always #(HALF_PERIOD) clk = ~clk;

    weekly_mode_schedule_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wmst_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Stall the result side at random, except during a steady stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic in_t pack_item(input logic op, input int day, input int hr,
                                      input int mn, input int run, input int dhw,
                                      input logic auto_on);
        in_t it;
        it.operation   = op;
        it.weekday     = DAY_W'(day);
        it.hour        = HOUR_W'(hr);
        it.minute      = MINUTE_W'(mn);
        it.run_target  = MODE_W'(run);
        it.dhw_target  = MODE_W'(dhw);
        it.auto_active = auto_on;
        return it;
    endfunction

    // Mostly well-formed adds and ticks, with some out-of-range fields mixed in
    function automatic in_t random_item(input logic [MODE_W-1:0] unk);
        in_t it;
        it = in_t'($bits(in_t)'($urandom));
        it.operation = ($urandom_range(99) < ADD_PCT) ? OP_ADD : OP_TICK;
        if ($urandom_range(9) != 0)
            it.weekday = DAY_W'($urandom_range(LAST_DAY));
        if ($urandom_range(9) != 0)
        begin
            it.hour = HOUR_W'($urandom_range(MAX_HOUR));
            it.minute = MINUTE_W'($urandom_range(MAX_MINUTE));
            // Favor whole hours so equal times collide
            if ($urandom_range(3) == 0)
                it.minute = '0;
        end
        if (it.operation == OP_ADD && $urandom_range(9) != 0)
        begin
            it.run_target = MODE_W'($urandom_range(unk));
            it.dhw_target = MODE_W'($urandom_range(unk));
        end
        if (it.operation == OP_TICK)
            it.auto_active = ($urandom_range(9) != 0);
        return it;
    endfunction

    // Present one item, idling at random first; valid stays high afterward
    task automatic send_item(input in_t it);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every result has been transferred
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MODE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_modes(input logic [MODE_W-1:0] unk, input logic [MODE_W-1:0] frost);
        cfg_write(CFG_UNKNOWN_MODE, unk);
        cfg_write(CFG_FROSTFREE_MODE, frost);
        cfg_valid <= 1'b0;
        cur_unk = unk;
    endtask

    // Random items; hold off once at hold_at, no idling for the first steady_len
    task automatic run_phase(input int count, input int hold_at, input int steady_len);
        for (int k = 0; k < count; k++)
        begin
            if (k == hold_at)
                drain();
            steady = (k < steady_len);
            send_item(random_item(cur_unk));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_UNKNOWN_MODE;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty week, bad arguments, unknown modes, walking back, equal times
        send_item(pack_item(OP_TICK, 0, 12, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_TICK, 7, 12, 0, 15, 15, 1'b1));
        send_item(pack_item(OP_TICK, 1, 10, 0, 0, 0, 1'b0));
        send_item(pack_item(OP_ADD, 7, 8, 0, 1, 1, 1'b1));
        send_item(pack_item(OP_ADD, 2, 24, 0, 1, 1, 1'b0));
        send_item(pack_item(OP_ADD, 2, 10, 60, 1, 1, 1'b1));
        send_item(pack_item(OP_ADD, 2, 10, 0, 8, 1, 1'b1));
        send_item(pack_item(OP_ADD, 2, 10, 0, 1, 15, 1'b1));
        send_item(pack_item(OP_ADD, 3, 8, 0, 7, 7, 1'b1));
        send_item(pack_item(OP_TICK, 3, 9, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_ADD, 2, 23, 59, 2, 3, 1'b0));
        send_item(pack_item(OP_TICK, 3, 7, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_ADD, 3, 8, 0, 4, 7, 1'b1));
        send_item(pack_item(OP_TICK, 3, 8, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_TICK, 3, 8, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_ADD, 0, 0, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_TICK, 0, 31, 63, 15, 15, 1'b1));
        send_item(pack_item(OP_TICK, 4, 0, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_TICK, 1, 0, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_ADD, 6, 0, 0, 0, 7, 1'b1));
        send_item(pack_item(OP_TICK, 6, 0, 0, 0, 0, 1'b1));
        send_item(pack_item(OP_TICK, 0, 0, 0, 0, 0, 1'b0));

        // Fill one day with random entries, then overflow it
        for (int k = 0; k <= ENTRIES_PER_DAY_DEF; k++)
            send_item(pack_item(OP_ADD, FILL_DAY, $urandom_range(MAX_HOUR),
                                $urandom_range(MAX_MINUTE), $urandom_range(cur_unk),
                                $urandom_range(cur_unk), 1'b1));

        // Random phases over several register settings, extremes included
        drain();
        set_modes(UNKNOWN_MODE_RST, FROSTFREE_MODE_RST);
        run_phase(400, 200, 0);
        drain();
        set_modes('1, '0);
        run_phase(400, -1, 0);
        drain();
        set_modes('0, '1);
        run_phase(300, -1, 0);
        drain();
        cfg_write(CFG_SPARE, MODE_W'($urandom));
        set_modes(MODE_W'($urandom), MODE_W'($urandom));
        run_phase(400, -1, 0);
        drain();
        set_modes(UNKNOWN_MODE_RST, MODE_W'($urandom));
        run_phase(500, -1, 300);
        drain();

        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
